// ===== design/segmented_lru4_cache_policy_defines.svh =====
// ----------------------------------------------------------------------------
// Segmented LRU cache policy: assertion macros
// Shared macros for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SEGMENTED_LRU4_CACHE_POLICY_DEFINES_SVH
`define SEGMENTED_LRU4_CACHE_POLICY_DEFINES_SVH

// property sampled on the rising clock, off while reset is low
`define S4_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// implication held only while a result is shown
`define S4_ASSERT_OUT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        o_out_valid |-> (cond)) else $error(msg);

`endif

// ===== design/s4lru_pkg.sv =====
// ----------------------------------------------------------------------------
// s4lru_pkg
// Types and constants shared by the segmented LRU controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package s4lru_pkg;
    localparam int KEY_W  = 31;
    localparam int CAP_W  = 5;
    localparam int HSEG_W = 2;
    localparam int SEG_W  = 3;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [2:0] {
        OP_NOP     = 3'd0,
        OP_LOAD    = 3'd1,
        OP_LOOK    = 3'd2,
        OP_REMOVE  = 3'd3,
        OP_INSERT  = 3'd4,
        OP_PUBLISH = 3'd5
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [SEG_W-1:0] seg;
        logic             use_gone;
    } t_cmd;

    typedef struct packed {
        logic             hit;
        logic             top;
        logic [SEG_W-1:0] seg;
        logic             gone_v;
    } t_status;
endpackage
`default_nettype wire

// ===== design/s4lru_datapath.sv =====
// ----------------------------------------------------------------------------
// s4lru_datapath
// Entry store with parallel tag compare, per-segment rank update, output regs.
// ----------------------------------------------------------------------------
`default_nettype none
module s4lru_datapath import s4lru_pkg::*; #(
    parameter int SEGMENT_COUNT = 4,
    parameter int SEGMENT_DEPTH = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [CAP_W-1:0]  i_cfg_wr_data,
    input  wire logic [KEY_W-1:0]  i_access_key,
    input  wire t_cmd              i_cmd,
    output t_status                o_status,
    output logic                   o_hit,
    output logic [HSEG_W-1:0]      o_hit_segment,
    output logic                   o_dropped_valid,
    output logic [KEY_W-1:0]       o_dropped_key
);
    localparam int SC = SEGMENT_COUNT;
    localparam int SD = SEGMENT_DEPTH;
    localparam int SW = (SC > 1) ? $clog2(SC) : 1;
    localparam int RW = (SD > 1) ? $clog2(SD) : 1;
    localparam int FW = $clog2(SD + 1);

    logic [KEY_W-1:0] r_key  [SC][SD];
    logic [RW-1:0]    r_rank [SC][SD];
    logic [SD-1:0]    r_valid [SC];
    logic [FW-1:0]    r_fill  [SC];
    logic [CAP_W-1:0] r_cap;
    logic [KEY_W-1:0] r_in_key;
    logic             r_hit;
    logic [SW-1:0]    r_hseg;
    logic [SD-1:0]    r_hslot;
    logic [KEY_W-1:0] r_gone;
    logic             r_gone_v;

    logic [FW-1:0]    eff_cap;
    logic             l_hit;
    logic [SW-1:0]    l_seg;
    logic [SD-1:0]    l_slot;
    logic [SD-1:0]    match_row [SC];
    logic [SW-1:0]    ins_seg;
    logic [SD-1:0]    ins_v;
    logic [FW-1:0]    ins_fill;
    logic             ins_full;
    logic [SD-1:0]    lru_oh;
    logic [SD-1:0]    free_oh;
    logic [SD-1:0]    tgt_oh;
    logic [KEY_W-1:0] lru_key;
    logic [KEY_W-1:0] ins_key;
    logic [RW-1:0]    rem_rank;
    logic [RW-1:0]    lru_rank;

    always_comb begin
        if (r_cap == '0) begin
            eff_cap = FW'(1);
        end else if (32'(r_cap) > 32'(SD)) begin
            eff_cap = FW'(SD);
        end else begin
            eff_cap = FW'(r_cap);
        end
    end

    always_comb begin
        l_hit  = 1'b0;
        l_seg  = '0;
        l_slot = '0;
        for (int s = 0; s < SC; s++) begin
            for (int j = 0; j < SD; j++) begin
                match_row[s][j] = r_valid[s][j] && (r_key[s][j] == r_in_key);
            end
        end
        for (int s = SC - 1; s >= 0; s--) begin
            if (|match_row[s]) begin
                l_hit  = 1'b1;
                l_seg  = SW'(s);
                l_slot = match_row[s];
            end
        end
    end

    always_comb begin
        ins_seg  = i_cmd.seg[SW-1:0];
        ins_v    = r_valid[ins_seg];
        ins_fill = r_fill[ins_seg];
        ins_full = (ins_fill >= eff_cap);
        lru_rank = RW'(ins_fill - FW'(1));
        lru_key  = '0;
        rem_rank = '0;
        for (int j = 0; j < SD; j++) begin
            lru_oh[j] = ins_v[j] && (r_rank[ins_seg][j] == lru_rank);
            if (lru_oh[j]) begin
                lru_key = lru_key | r_key[ins_seg][j];
            end
            if (r_hslot[j]) begin
                rem_rank = rem_rank | r_rank[r_hseg][j];
            end
        end
        free_oh = ~ins_v & (ins_v + SD'(1));
        tgt_oh  = ins_full ? lru_oh : free_oh;
        ins_key = i_cmd.use_gone ? r_gone : r_in_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
            for (int s = 0; s < SC; s++) begin
                r_valid[s] <= '0;
                r_fill[s]  <= '0;
            end
        end else if (i_cfg_wr_en) begin
            r_cap <= i_cfg_wr_data;
            for (int s = 0; s < SC; s++) begin
                r_valid[s] <= '0;
                r_fill[s]  <= '0;
            end
        end else begin
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_in_key <= i_access_key;
                end
                OP_LOOK: begin
                    r_hit   <= l_hit;
                    r_hseg  <= l_seg;
                    r_hslot <= l_slot;
                end
                OP_REMOVE: begin
                    for (int j = 0; j < SD; j++) begin
                        if (r_valid[r_hseg][j] && (r_rank[r_hseg][j] > rem_rank)) begin
                            r_rank[r_hseg][j] <= r_rank[r_hseg][j] - RW'(1);
                        end
                    end
                    r_valid[r_hseg] <= r_valid[r_hseg] & ~r_hslot;
                    r_fill[r_hseg]  <= r_fill[r_hseg] - FW'(1);
                end
                OP_INSERT: begin
                    for (int j = 0; j < SD; j++) begin
                        if (tgt_oh[j]) begin
                            r_key[ins_seg][j]  <= ins_key;
                            r_rank[ins_seg][j] <= '0;
                        end else if (ins_v[j]) begin
                            r_rank[ins_seg][j] <= r_rank[ins_seg][j] + RW'(1);
                        end
                    end
                    r_valid[ins_seg] <= ins_v | tgt_oh;
                    if (!ins_full) begin
                        r_fill[ins_seg] <= ins_fill + FW'(1);
                    end
                    r_gone_v <= ins_full;
                    if (ins_full) begin
                        r_gone <= lru_key;
                    end
                end
                OP_PUBLISH: begin
                    o_hit           <= r_hit;
                    o_hit_segment   <= r_hit ? HSEG_W'(r_hseg) : '0;
                    o_dropped_valid <= !r_hit && r_gone_v;
                    o_dropped_key   <= (!r_hit && r_gone_v) ? r_gone : '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_status.hit    = r_hit;
    assign o_status.top    = (r_hseg == SW'(SC - 1));
    assign o_status.seg    = SEG_W'(r_hseg);
    assign o_status.gone_v = r_gone_v;
endmodule
`default_nettype wire

// ===== design/s4lru_ctrl.sv =====
// ----------------------------------------------------------------------------
// s4lru_ctrl
// Sequencer for lookup, removal and inserts; owns the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none
module s4lru_ctrl import s4lru_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_LOOK = 6'b000010,
        ST_ACT  = 6'b000100,
        ST_INS1 = 6'b001000,
        ST_INS2 = 6'b010000,
        ST_FIN  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   can_pub;

    assign can_pub = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '{op: OP_NOP, seg: '0, use_gone: 1'b0};
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_LOOK;
                end
            end
            ST_LOOK: begin
                o_cmd.op = OP_LOOK;
                n_state  = ST_ACT;
            end
            ST_ACT: begin
                if (!i_status.hit) begin
                    o_cmd.op = OP_INSERT;
                    n_state  = ST_FIN;
                end else begin
                    o_cmd.op = OP_REMOVE;
                    n_state  = ST_INS1;
                end
            end
            ST_INS1: begin
                o_cmd.op  = OP_INSERT;
                o_cmd.seg = i_status.top ? i_status.seg : i_status.seg + SEG_W'(1);
                n_state   = i_status.top ? ST_FIN : ST_INS2;
            end
            ST_INS2: begin
                if (i_status.gone_v) begin
                    o_cmd.op       = OP_INSERT;
                    o_cmd.seg      = i_status.seg;
                    o_cmd.use_gone = 1'b1;
                end
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (can_pub) begin
                    o_cmd.op    = OP_PUBLISH;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
endmodule
`default_nettype wire

// ===== design/segmented_lru4_cache_policy.sv =====
// Sequence: load, lookup, then an insert on a miss; on a top-segment hit, removal and
// an insert; on a hit in a lower segment, removal and one or two inserts; then publish.
// At most one entry-store operation per cycle; a new key is taken only after publish.
// Reset (synchronous, active low) empties all segments and sets capacity 16.
// A capacity write also empties all segments.
`default_nettype none
// ----------------------------------------------------------------------------
// segmented_lru4_cache_policy
// Segmented LRU replacement policy, top level: controller plus datapath.
// ----------------------------------------------------------------------------
module segmented_lru4_cache_policy import s4lru_pkg::*; #(
    parameter int SEGMENT_COUNT = 4,
    parameter int SEGMENT_DEPTH = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [CAP_W-1:0]  i_cfg_wr_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [KEY_W-1:0]  i_access_key,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_hit,
    output logic [HSEG_W-1:0]      o_hit_segment,
    output logic                   o_dropped_valid,
    output logic [KEY_W-1:0]       o_dropped_key
);
    t_cmd    cmd;
    t_status status;

    s4lru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    s4lru_datapath #(
        .SEGMENT_COUNT (SEGMENT_COUNT),
        .SEGMENT_DEPTH (SEGMENT_DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_access_key    (i_access_key),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_hit           (o_hit),
        .o_hit_segment   (o_hit_segment),
        .o_dropped_valid (o_dropped_valid),
        .o_dropped_key   (o_dropped_key)
    );
endmodule
`default_nettype wire

// ===== design/s4lru_checker.sv =====
// ----------------------------------------------------------------------------
// s4lru_checker
// Port-level checks of the segmented LRU policy, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "segmented_lru4_cache_policy_defines.svh"
module s4lru_checker import s4lru_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_stall,
    input wire logic              o_out_valid,
    input wire logic              o_hit,
    input wire logic [HSEG_W-1:0] o_hit_segment,
    input wire logic              o_dropped_valid,
    input wire logic [KEY_W-1:0]  o_dropped_key
);
    `S4_ASSERT_OUT(a_hit_no_drop, !(o_hit && o_dropped_valid), "drop reported on a hit")
    `S4_ASSERT_OUT(a_miss_seg0, o_hit || (o_hit_segment == '0), "miss with nonzero segment")
    `S4_ASSERT_OUT(a_drop_key0, o_dropped_valid || (o_dropped_key == '0), "stale dropped key")
    `S4_ASSERT(a_busy_after, (i_in_valid && !o_in_stall) |=> o_in_stall, "no stall after transfer")
endmodule

bind segmented_lru4_cache_policy s4lru_checker u_s4lru_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .o_hit           (o_hit),
    .o_hit_segment   (o_hit_segment),
    .o_dropped_valid (o_dropped_valid),
    .o_dropped_key   (o_dropped_key)
);
`default_nettype wire

// ===== tb/segmented_lru4_cache_policy_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segmented_lru4_cache_policy_test
// Drives access keys through the segmented LRU policy. A behavioral model of
// the four segments predicts every result, and a scoreboard compares them.
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct {
    logic              hit;
    logic [1:0]        hit_segment;
    logic              dropped_valid;
    logic [30:0]       dropped_key;
} t_s4_result;

class s4_scoreboard;
    localparam int NSEG  = 4;
    localparam int DEPTH = 16;
    logic [30:0] keys  [NSEG*DEPTH];
    bit          valid [NSEG*DEPTH];
    int          rank  [NSEG*DEPTH];
    int          fill  [NSEG];
    int          capacity;
    t_s4_result  pending[$];
    int          errors;

    function new();
        capacity = 16;
        errors = 0;
        flush();
    endfunction

    function void flush();
        for (int p = 0; p < NSEG*DEPTH; p++) begin
            valid[p] = 0;
            rank[p] = 0;
        end
        for (int s = 0; s < NSEG; s++) fill[s] = 0;
    endfunction

    function void set_capacity(logic [4:0] v);
        capacity = int'(v);
        flush();
    endfunction

    function int eff_cap();
        if (capacity < 1) return 1;
        if (capacity > DEPTH) return DEPTH;
        return capacity;
    endfunction

    function void unlink(int seg, int slot);
        int r;
        r = rank[slot];
        for (int j = 0; j < DEPTH; j++)
            if (valid[seg*DEPTH+j] && rank[seg*DEPTH+j] > r) rank[seg*DEPTH+j]--;
        valid[slot] = 0;
        rank[slot] = 0;
        if (fill[seg] > 0) fill[seg]--;
    endfunction

    function bit push_front(int seg, logic [30:0] key, output logic [30:0] gone);
        int old, worst, free_slot, p;
        bit out;
        old = -1; worst = 0; free_slot = -1; out = 0; gone = 0;
        if (fill[seg] >= eff_cap()) begin
            for (int j = 0; j < DEPTH; j++) begin
                p = seg*DEPTH + j;
                if (valid[p] && (old < 0 || rank[p] >= worst)) begin
                    old = p;
                    worst = rank[p];
                end
            end
            if (old >= 0) begin
                gone = keys[old];
                out = 1;
                unlink(seg, old);
            end
        end
        for (int j = 0; j < DEPTH; j++) begin
            p = seg*DEPTH + j;
            if (valid[p]) rank[p]++;
            else if (free_slot < 0) free_slot = p;
        end
        if (free_slot >= 0) begin
            keys[free_slot] = key;
            valid[free_slot] = 1;
            rank[free_slot] = 0;
            fill[seg]++;
        end
        return out;
    endfunction

    function void note_access(logic [30:0] key);
        int seg, slot;
        logic [30:0] gone, lost;
        t_s4_result r;
        seg = -1; slot = -1;
        for (int s = 0; s < NSEG && seg < 0; s++)
            for (int j = 0; j < DEPTH; j++)
                if (slot < 0 && valid[s*DEPTH+j] && keys[s*DEPTH+j] == key) begin
                    seg = s;
                    slot = s*DEPTH + j;
                end
        if (seg < 0) begin
            r.hit = 0;
            r.hit_segment = 0;
            r.dropped_valid = push_front(0, key, gone);
            r.dropped_key = r.dropped_valid ? gone : 31'd0;
        end else begin
            unlink(seg, slot);
            if (seg == NSEG-1) void'(push_front(seg, key, gone));
            else if (push_front(seg+1, key, gone)) void'(push_front(seg, gone, lost));
            r.hit = 1;
            r.hit_segment = seg[1:0];
            r.dropped_valid = 0;
            r.dropped_key = 0;
        end
        pending.push_back(r);
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h", what, got, want);
        errors++;
    endfunction

    function void check_result(t_s4_result got);
        t_s4_result w;
        if (pending.size() == 0) begin
            report("unexpected transfer", 0, 0);
            return;
        end
        w = pending.pop_front();
        if (got.hit !== w.hit) report("hit", 32'(got.hit), 32'(w.hit));
        if (got.hit_segment !== w.hit_segment)
            report("hit_segment", 32'(got.hit_segment), 32'(w.hit_segment));
        if (got.dropped_valid !== w.dropped_valid)
            report("dropped_valid", 32'(got.dropped_valid), 32'(w.dropped_valid));
        if (got.dropped_key !== w.dropped_key)
            report("dropped_key", 32'(got.dropped_key), 32'(w.dropped_key));
    endfunction
endclass

module segmented_lru4_cache_policy_test;
    import s4lru_pkg::*;

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_cfg_wr_en = 0;
    logic [CAP_W-1:0]  i_cfg_wr_data = 0;
    logic              i_in_valid = 0;
    logic              o_in_stall;
    logic [KEY_W-1:0]  i_access_key = 0;
    logic              o_out_valid;
    logic              i_out_stall = 0;
    logic              o_hit;
    logic [HSEG_W-1:0] o_hit_segment;
    logic              o_dropped_valid;
    logic [KEY_W-1:0]  o_dropped_key;

    s4_scoreboard sb;
    bit  quiet_tail = 0;
    bit  done = 0;
    int  idle_cycles = 0;
    int  key_pool [32];

    segmented_lru4_cache_policy uut (.*);

    always #10 i_clk = ~i_clk;

    // result side: random stall bursts, check on each transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                t_s4_result r;
                r.hit = o_hit;
                r.hit_segment = o_hit_segment;
                r.dropped_valid = o_dropped_valid;
                r.dropped_key = o_dropped_key;
                sb.check_result(r);
            end
        end
    end

    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 6);
                i_out_stall <= 1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 0;
        end
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000 && !done) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_key(logic [30:0] key);
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_access_key <= key;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_access(key);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [4:0] v);
        drain();
        i_cfg_wr_en <= 1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        sb.set_capacity(v);
        i_cfg_wr_en <= 0;
        @(posedge i_clk);
    endtask

    task automatic random_phase(int count, int pool);
        logic [30:0] k;
        for (int i = 0; i < pool; i++) key_pool[i] = {$urandom()} & 32'h7fffffff;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0) k = 31'($urandom());
            else k = 31'(key_pool[$urandom_range(0, pool-1)]);
            send_key(k);
        end
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, promotion through all segments, drop from segment 0
        send_key(31'd0);
        send_key(31'h7fffffff);
        send_key(31'h55555555);
        send_key(31'h2aaaaaaa);
        for (int i = 0; i < 5; i++) send_key(31'h7fffffff);
        send_key(31'd0);
        write_capacity(5'd1);
        send_key(31'd1);
        send_key(31'd2);
        send_key(31'd2);
        send_key(31'd3);
        send_key(31'd3);
        send_key(31'd1);
        write_capacity(5'd0);
        send_key(31'd7);
        send_key(31'd8);
        send_key(31'd8);
        send_key(31'd7);
        write_capacity(5'd31);
        send_key(31'd9);
        send_key(31'd9);

        write_capacity(5'd2);
        random_phase(250, 10);
        write_capacity(5'd16);
        random_phase(300, 32);
        write_capacity(5'd4);
        random_phase(250, 20);
        write_capacity(5'd1);
        random_phase(150, 6);
        write_capacity(5'd17);
        random_phase(200, 32);
        quiet_tail = 1;
        write_capacity(5'd3);
        random_phase(200, 16);

        drain();
        done = 1;
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
